### src/rau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Operation codes, status codes, widths and the front-to-back work record.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OperandWidthDefault = 32;
   localparam int QueueDepthDefault   = 2;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_LESS  = 3'd4,
      OP_EQUAL = 3'd5,
      OP_NOP6  = 3'd6,
      OP_NOP7  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_UNUSED   = 2'd3
   } status_type;

   // Operands in sign/magnitude form with positive denominators.
   typedef struct packed {
      op_type      op;
      logic        zero_den;
      logic        a_neg;
      logic [31:0] a_mag;
      logic [31:0] a_den;
      logic        b_neg;
      logic [31:0] b_mag;
      logic [31:0] b_den;
   } work_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RED_A,
      S_DIV_A,
      S_RED_B,
      S_DIV_B,
      S_MUL1,
      S_MUL2,
      S_COMBINE,
      S_RED_R,
      S_DIV_R,
      S_DONE
   } state_type;

endpackage : rau_pkg
`default_nettype wire

### src/rau_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic front end
// Takes request beats, sign-extends and classifies the operands and queues
// them in sign/magnitude form for the back end.
// ----------------------------------------------------------------------------
module rau_front #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault,
   parameter int QUEUE_DEPTH   = rau_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_kind,
   input  wire logic [31:0]       req_a_num,
   input  wire logic [31:0]       req_a_den,
   input  wire logic [31:0]       req_b_num,
   input  wire logic [31:0]       req_b_den,
   output logic                   work_valid,
   input  wire logic              work_take,
   output rau_pkg::work_type      work_data
);
   import rau_pkg::*;

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   work_type               queue_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]      count_ff, count_in;
   work_type               entry;
   logic                   push, pop;
   logic [31:0]            an, ad, bn, bd;

   function automatic logic [31:0] sext(input logic [31:0] v);
      return {{(32-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
   endfunction

   function automatic logic [31:0] absv(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   always_comb begin
      an = sext(req_a_num);
      ad = sext(req_a_den);
      bn = sext(req_b_num);
      bd = sext(req_b_den);
      entry.op       = op_type'(req_kind);
      entry.zero_den = (ad == 32'd0) || (bd == 32'd0);
      entry.a_neg    = an[31] ^ ad[31];
      entry.a_mag    = absv(an);
      entry.a_den    = absv(ad);
      entry.b_neg    = bn[31] ^ bd[31];
      entry.b_mag    = absv(bn);
      entry.b_den    = absv(bd);
   end

   assign req_stall  = (count_ff == (PtrWidth+1)'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign work_valid = (count_ff != '0);
   assign pop        = work_valid && work_take;
   assign work_data  = queue_ff[rd_ptr_ff];

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule : rau_front
`default_nettype wire

### src/rau_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic shared divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle; used both
// for the Euclid remainders and for the final reductions.
// ----------------------------------------------------------------------------
module rau_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient,
   output logic [63:0]      remainder
);
   import rau_pkg::*;

   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule : rau_divider
`default_nettype wire

### src/rau_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic back end
// Sequencer that reduces both operands, forms the exact result with 32x32
// products, reduces arithmetic results and holds each response in the response register.
// ----------------------------------------------------------------------------
module rau_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              work_valid,
   output logic                   work_take,
   input  rau_pkg::work_type      work_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [63:0]            rsp_res_num,
   output logic [62:0]            rsp_res_den,
   output logic                   rsp_is_less,
   output logic                   rsp_is_equal,
   output logic [1:0]             rsp_status
);
   import rau_pkg::*;

   state_type   state_ff, state_in;
   work_type    w_ff;
   // Euclid pair, then the fraction being reduced (num/den).
   logic [63:0] gx_ff, gy_ff, num_ff, den_ff;
   logic        neg_ff;
   logic [63:0] p1_ff, p2_ff, p3_ff;
   logic [31:0] am_ff, ad_ff, bm_ff, bd_ff;
   logic        an_ff, bn_ff;
   logic [1:0]  div_phase_ff; // 0 gcd step, 1 numerator, 2 denominator
   logic        div_busy_ff;
   logic        div_start;
   logic [63:0] div_a, div_b, div_q, div_r;
   logic        div_done;

   logic        out_valid_ff;
   logic [63:0] out_num_ff, out_num_in;
   logic [62:0] out_den_ff, out_den_in;
   logic        out_less_ff, out_less_in, out_equal_ff, out_equal_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_load;
   logic [63:0] sat_mag;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   assign work_take = (state_ff == S_IDLE) && work_valid;

   logic        red_state;
   logic        sum_neg;
   logic [63:0] sum_mag;
   logic        bneg_eff;
   logic        lt;
   logic [63:0] gcd_v;

   always_comb begin
      red_state = (state_ff == S_RED_A) || (state_ff == S_RED_B) ||
                  (state_ff == S_RED_R);
      gcd_v     = (gx_ff == 64'd0) ? 64'd1 : gx_ff;
      div_start = 1'b0;
      div_a     = gx_ff;
      div_b     = gy_ff;
      if (red_state && !div_busy_ff && gy_ff != 64'd0) begin
         div_start = 1'b1;
      end else if (!div_busy_ff &&
                   (state_ff == S_DIV_A || state_ff == S_DIV_B ||
                    state_ff == S_DIV_R) && div_phase_ff != 2'd0) begin
         div_start = 1'b1;
         div_a     = (div_phase_ff == 2'd1) ? num_ff : den_ff;
         div_b     = gcd_v;
      end
      bneg_eff = (w_ff.op == OP_SUB) ? !bn_ff : bn_ff;
      if (an_ff == bneg_eff) begin
         sum_neg = an_ff;
         sum_mag = p1_ff + p2_ff;
      end else if (p1_ff >= p2_ff) begin
         sum_neg = an_ff;
         sum_mag = p1_ff - p2_ff;
      end else begin
         sum_neg = bneg_eff;
         sum_mag = p2_ff - p1_ff;
      end
      // Signed compare of a_num*b_den against b_num*a_den in sign/magnitude.
      if (an_ff != bn_ff) lt = an_ff && (p1_ff != 0 || p2_ff != 0);
      else if (an_ff)     lt = p1_ff > p2_ff;
      else                lt = p1_ff < p2_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (work_valid) state_in = S_RED_A;
         S_RED_A:   if (!div_busy_ff && gy_ff == 0) state_in = S_DIV_A;
         S_DIV_A:   if (div_done && div_phase_ff == 2'd2) state_in = S_RED_B;
         S_RED_B:   if (!div_busy_ff && gy_ff == 0) state_in = S_DIV_B;
         S_DIV_B:   if (div_done && div_phase_ff == 2'd2) state_in = S_MUL1;
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = S_COMBINE;
         S_COMBINE: state_in = S_RED_R;
         S_RED_R:   if (!div_busy_ff && gy_ff == 0) state_in = S_DIV_R;
         S_DIV_R:   if (div_done && div_phase_ff == 2'd2) state_in = S_DONE;
         S_DONE:    if (!out_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
      // Errors, comparisons and unused codes skip the result reduction.
      if (state_ff == S_IDLE && work_valid && work_data.zero_den) state_in = S_DONE;
      if (state_ff == S_COMBINE &&
          (w_ff.op == OP_LESS || w_ff.op == OP_EQUAL || w_ff.op == OP_NOP6 ||
           w_ff.op == OP_NOP7 || (w_ff.op == OP_DIV && bm_ff == 0)))
         state_in = S_DONE;
   end

   // Next response beat; the numerator magnitude saturates at 2^63-1.
   always_comb begin
      out_load      = (state_ff == S_DONE) && (!out_valid_ff || !rsp_stall);
      sat_mag       = {1'b0, (num_ff[63] ? 63'h7FFF_FFFF_FFFF_FFFF : num_ff[62:0])};
      out_num_in    = '0;
      out_den_in    = 63'd1;
      out_less_in   = 1'b0;
      out_equal_in  = 1'b0;
      out_status_in = ST_OK;
      priority if (w_ff.zero_den) begin
         out_status_in = ST_ZERO_DEN;
      end else if (w_ff.op == OP_DIV && bm_ff == 0) begin
         out_status_in = ST_DIV_ZERO;
      end else if (w_ff.op == OP_LESS) begin
         out_less_in = lt;
      end else if (w_ff.op == OP_EQUAL) begin
         out_equal_in = (an_ff == bn_ff) && (am_ff == bm_ff) && (ad_ff == bd_ff);
      end else if (w_ff.op == OP_NOP6 || w_ff.op == OP_NOP7) begin
         out_status_in = ST_OK;
      end else begin
         out_num_in = (neg_ff && num_ff != 0) ? (64'd0 - sat_mag) : sat_mag;
         out_den_in = den_ff[62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_busy_ff  <= 1'b0;
         div_phase_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_start) div_busy_ff <= 1'b1;
         else if (div_done) div_busy_ff <= 1'b0;
         if (red_state && state_in != state_ff) div_phase_ff <= 2'd1;
         else if (div_done && div_phase_ff == 2'd1) div_phase_ff <= 2'd2;
         else if (div_done && div_phase_ff == 2'd2) div_phase_ff <= 2'd0;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_valid && !rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (work_take) begin
         w_ff   <= work_data;
         gx_ff  <= {32'd0, work_data.a_mag};
         gy_ff  <= {32'd0, work_data.a_den};
         num_ff <= {32'd0, work_data.a_mag};
         den_ff <= {32'd0, work_data.a_den};
      end
      if (red_state && div_done && div_phase_ff == 2'd0) begin
         gx_ff <= gy_ff;
         gy_ff <= div_r;
      end
      if (div_done && div_phase_ff == 2'd1) num_ff <= div_q;
      if (div_done && div_phase_ff == 2'd2) begin
         if (state_ff == S_DIV_A) begin
            am_ff <= num_ff[31:0];
            ad_ff <= div_q[31:0];
            an_ff <= w_ff.a_neg && num_ff != 0;
            gx_ff <= {32'd0, w_ff.b_mag};
            gy_ff <= {32'd0, w_ff.b_den};
            num_ff <= {32'd0, w_ff.b_mag};
            den_ff <= {32'd0, w_ff.b_den};
         end else begin
            den_ff <= div_q;
         end
         if (state_ff == S_DIV_B) begin
            bm_ff <= num_ff[31:0];
            bd_ff <= div_q[31:0];
            bn_ff <= w_ff.b_neg && num_ff != 0;
         end
      end
      // The 32x32 products are formed in S_MUL1 (p1 and p3) and S_MUL2 (p2).
      if (state_ff == S_MUL1) begin
         p1_ff <= (w_ff.op == OP_MUL) ? am_ff * bm_ff : am_ff * bd_ff;
         p3_ff <= ad_ff * bd_ff;
      end
      if (state_ff == S_MUL2) begin
         p2_ff <= (w_ff.op == OP_DIV) ? ad_ff * bm_ff : bm_ff * ad_ff;
      end
      if (state_ff == S_COMBINE) begin
         unique case (w_ff.op)
            OP_ADD, OP_SUB: begin
               neg_ff <= sum_neg;
               num_ff <= sum_mag;
               den_ff <= p3_ff;
            end
            OP_MUL: begin
               neg_ff <= an_ff ^ bn_ff;
               num_ff <= p1_ff;
               den_ff <= p3_ff;
            end
            default: begin
               neg_ff <= an_ff ^ bn_ff;
               num_ff <= p1_ff;
               den_ff <= p2_ff;
            end
         endcase
         gx_ff <= (w_ff.op == OP_ADD || w_ff.op == OP_SUB) ? sum_mag :
                  (w_ff.op == OP_MUL) ? p1_ff : p1_ff;
         gy_ff <= (w_ff.op == OP_DIV) ? p2_ff : p3_ff;
      end
      if (out_load) begin
         out_num_ff    <= out_num_in;
         out_den_ff    <= out_den_in;
         out_less_ff   <= out_less_in;
         out_equal_ff  <= out_equal_in;
         out_status_ff <= out_status_in;
      end
   end

   // In compare mode the products hold a_num*b_den (p1) and b_num*a_den (p2).
   assign rsp_valid    = out_valid_ff;
   assign rsp_res_num  = out_num_ff;
   assign rsp_res_den  = out_den_ff;
   assign rsp_is_less  = out_less_ff;
   assign rsp_is_equal = out_equal_ff;
   assign rsp_status   = out_status_ff;

endmodule : rau_back
`default_nettype wire

### src/rational_arithmetic_unit.sv
`default_nettype none
// Each request beat is classified by the front end and queued; the back end
// then handles one item at a time with a shared radix-2 64-bit divider.
// Reducing both operands and the result takes three Euclid passes plus two
// quotient divisions each. A zero denominator is answered without a division,
// a comparison reduces only the operands, and an arithmetic result also goes
// through the result reduction. The queue accepts new beats, until it is full,
// while the back end works and while a response waits for the receiver.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Top level: front end, work queue and back end.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_a_num,
   input  wire logic [31:0] req_a_den,
   input  wire logic [31:0] req_b_num,
   input  wire logic [31:0] req_b_den,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_res_num,
   output logic [62:0]      rsp_res_den,
   output logic             rsp_is_less,
   output logic             rsp_is_equal,
   output logic [1:0]       rsp_status
);
   import rau_pkg::*;

   logic     work_valid, work_take;
   work_type work_data;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH), .QUEUE_DEPTH(QueueDepthDefault)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_a_num,
      .req_a_den, .req_b_num, .req_b_den, .work_valid, .work_take, .work_data
   );

   rau_back u_back (
      .clock, .reset, .work_valid, .work_take, .work_data, .rsp_valid,
      .rsp_stall, .rsp_res_num, .rsp_res_den, .rsp_is_less, .rsp_is_equal,
      .rsp_status
   );

endmodule : rational_arithmetic_unit
`default_nettype wire

### src/rau_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic port checker
// Watches the top level's ports for response consistency.
// ----------------------------------------------------------------------------
module rau_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_res_num,
   input wire logic [62:0] rsp_res_den,
   input wire logic        rsp_is_less,
   input wire logic        rsp_is_equal,
   input wire logic [1:0]  rsp_status
);
   import rau_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num))
      else $error("stalled response beat changed");

   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != 63'd0)
      else $error("zero denominator in response");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_res_num == 64'd0 && rsp_res_den == 63'd1 && !rsp_is_less && !rsp_is_equal)
      else $error("error response carries data");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_less && rsp_is_equal))
      else $error("both compare flags set");

endmodule : rau_checker

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_res_num, .rsp_res_den,
   .rsp_is_less, .rsp_is_equal, .rsp_status
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs through every operation with bursty requests and a
// stalling receiver, predicts each reduced result and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
   import rau_pkg::*;

   localparam longint CycleLimit = 100_000_000;
   localparam int     SettleCycles = 12_000;
   localparam logic [63:0] MagMax = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      op_type      kind;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
      bit          drain_first;
   } request_type;

   typedef struct {
      logic [63:0] res_num;
      logic [62:0] res_den;
      logic        is_less;
      logic        is_equal;
      status_type  status;
   } answer_type;

   typedef struct {
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
   } fraction_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_a_num = '0;
   logic [31:0] req_a_den = '0;
   logic [31:0] req_b_num = '0;
   logic [31:0] req_b_den = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_res_num;
   logic [62:0] rsp_res_den;
   logic        rsp_is_less;
   logic        rsp_is_equal;
   logic [1:0]  rsp_status;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   request_type current_request;
   int       mismatch_count = 0;
   int       accepted_count = 0;
   int       checked_count = 0;
   int       kind_count[8];
   int       status_count[4];
   longint   cycle_count = 0;

   rational_arithmetic_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(bit neg, logic [63:0] mag,
                                                    logic [63:0] den);
      fraction_type f;
      logic [63:0] g;
      g = gcd64(mag, den);
      if (g == 0) g = 1;
      f.mag = mag / g;
      f.den = den / g;
      f.neg = neg && (f.mag != 0);
      return f;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic fraction_type operand_fraction(logic [31:0] num, logic [31:0] den);
      longint n, d;
      n = longint'($signed(num));
      d = longint'($signed(den));
      return reduce_fraction((n < 0) != (d < 0), magnitude(n), magnitude(d));
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type   ans;
      fraction_type a, b, q;
      bit          neg, bneg;
      logic [63:0] m1, m2, mag;
      longint      lhs, rhs;
      ans = '{res_num: '0, res_den: 63'd1, is_less: 1'b0, is_equal: 1'b0, status: ST_OK};
      q = '{neg: 1'b0, mag: '0, den: 64'd1};
      if (r.a_den == 0 || r.b_den == 0) begin
         ans.status = ST_ZERO_DEN;
         return ans;
      end
      a = operand_fraction(r.a_num, r.a_den);
      b = operand_fraction(r.b_num, r.b_den);
      case (r.kind)
         OP_ADD, OP_SUB: begin
            m1 = a.mag * b.den;
            m2 = b.mag * a.den;
            bneg = (r.kind == OP_SUB) ? !b.neg : b.neg;
            if (a.neg == bneg) begin
               neg = a.neg; mag = m1 + m2;
            end else if (m1 >= m2) begin
               neg = a.neg; mag = m1 - m2;
            end else begin
               neg = bneg; mag = m2 - m1;
            end
            q = reduce_fraction(neg, mag, a.den * b.den);
         end
         OP_MUL: q = reduce_fraction(a.neg != b.neg, a.mag * b.mag, a.den * b.den);
         OP_DIV: begin
            if (b.mag == 0) ans.status = ST_DIV_ZERO;
            else q = reduce_fraction(a.neg != b.neg, a.mag * b.den, a.den * b.mag);
         end
         OP_LESS: begin
            lhs = (a.neg ? -longint'(a.mag) : longint'(a.mag)) * longint'(b.den);
            rhs = longint'(a.den) * (b.neg ? -longint'(b.mag) : longint'(b.mag));
            ans.is_less = (lhs < rhs);
         end
         OP_EQUAL: ans.is_equal = (a.neg == b.neg) && (a.mag == b.mag) && (a.den == b.den);
         default: ;
      endcase
      if (q.mag > MagMax) q.mag = MagMax;
      ans.res_num = q.neg ? -q.mag : q.mag;
      ans.res_den = q.den[62:0];
      return ans;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("mismatch at result %0d: %s got %0h expected %0h", checked_count, field, got,
               want);
   endtask

   // Sender: bursts of random length separated by random gaps.
   int  burst_left = 0;
   int  gap_left = 0;
   bit  offer;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_answers.push_back(predict_answer(current_request));
            kind_count[current_request.kind]++;
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && expected_answers.size() > 0)) begin
               offer = 1'b1;
               current_request = pending_requests.pop_front();
               req_kind <= current_request.kind;
               req_a_num <= current_request.a_num;
               req_a_den <= current_request.a_den;
               req_b_num <= current_request.b_num;
               req_b_den <= current_request.b_den;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left--;
               end
            end
            req_valid <= offer;
         end
      end
   end

   // Receiver: a stall rate that changes now and then, plus one long hold-off.
   int  stall_percent = 0;
   int  pattern_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && accepted_count >= 300) begin
            hold_done = 1'b1;
            hold_left = 6000;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(64, 2000);
            case ($urandom_range(0, 3))
               0: stall_percent = 0;
               1: stall_percent = 15;
               2: stall_percent = 50;
               default: stall_percent = 90;
            endcase
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_percent);
         end
      end
   end

   // Monitor: every result beat is checked against the oldest prediction.
   answer_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected beat res_num", rsp_res_num, '0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_res_num !== want.res_num)
               report_mismatch("res_num", rsp_res_num, want.res_num);
            if (rsp_res_den !== want.res_den)
               report_mismatch("res_den", rsp_res_den, want.res_den);
            if (rsp_is_less !== want.is_less)
               report_mismatch("is_less", rsp_is_less, want.is_less);
            if (rsp_is_equal !== want.is_equal)
               report_mismatch("is_equal", rsp_is_equal, want.is_equal);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            status_count[want.status]++;
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_answers.size());
         $display("** rational_arithmetic_unit: FAILED **");
         $finish;
      end
   end

   task automatic add_request(op_type kind, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                              logic [31:0] bd, bit drain = 1'b0);
      request_type r;
      r = '{kind: kind, a_num: an, a_den: ad, b_num: bn, b_den: bd, drain_first: drain};
      pending_requests.push_back(r);
   endtask

   // Mostly short values so the GCD chains stay short, with some full-width ones.
   function automatic logic [31:0] random_value(bit nonzero);
      logic [31:0] v;
      do begin
         case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, 200) - 100;
            3, 4:    v = $urandom;
            5:       v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         - $urandom_range(0, 2);
            default: v = ($urandom_range(1, 60) * $urandom_range(1, 3000))
                         * ($urandom_range(0, 1) ? 1 : -1);
         endcase
      end while (nonzero && v == 0);
      return v;
   endfunction

   function automatic logic [31:0] random_den();
      return ($urandom_range(0, 39) == 0) ? 32'd0 : random_value(1'b1);
   endfunction

   initial begin
      op_type k;
      for (int i = 0; i < 8; i++) kind_count[i] = 0;
      for (int i = 0; i < 4; i++) status_count[i] = 0;
      // Directed: every operation, extreme operands, zero denominators,
      // division by a zero numerator, unused codes and negative denominators.
      add_request(OP_ADD, 1, 2, 1, 3);
      add_request(OP_SUB, 1, 2, 1, 2);
      add_request(OP_MUL, -6, 4, 10, -15);
      add_request(OP_DIV, 3, -9, -2, 8);
      add_request(OP_LESS, -1, 3, 1, -3);
      add_request(OP_LESS, 1, 3, 1, 2);
      add_request(OP_EQUAL, 2, -4, -3, 6);
      add_request(OP_EQUAL, 2, 4, 3, 6);
      add_request(OP_ADD, 5, 0, 1, 1);
      add_request(OP_DIV, 1, 1, 7, 0);
      add_request(OP_DIV, 4, 7, 0, -5);
      add_request(OP_NOP6, 1, 2, 3, 4);
      add_request(OP_NOP7, 9, 1, 1, 1);
      add_request(OP_MUL, 0, -7, 5, 3);
      add_request(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      add_request(OP_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
      add_request(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      add_request(OP_DIV, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE);
      add_request(OP_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
      add_request(OP_LESS, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
      add_request(OP_EQUAL, 32'h8000_0000, 32'h8000_0000, 1, 1);
      add_request(OP_EQUAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 1280; i++) begin
         k = op_type'(($urandom_range(0, 49) == 0) ? $urandom_range(6, 7)
                                                   : $urandom_range(0, 5));
         add_request(k, random_value(1'b0), random_den(),
                     ($urandom_range(0, 19) == 0) ? 32'd0 : random_value(1'b0),
                     random_den(), (i == 500 || i == 1000));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("covered %0d requests: add %0d sub %0d mul %0d div %0d", accepted_count,
               kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
      $display("less %0d equal %0d unused %0d; ok %0d, zero denominator %0d, %s %0d; %0d cycles",
               kind_count[4], kind_count[5], kind_count[6] + kind_count[7], status_count[0],
               status_count[1], "division by zero", status_count[2], cycle_count);
      if (mismatch_count == 0 && checked_count == accepted_count) begin
         $display("** rational_arithmetic_unit: PASSED **");
      end else begin
         $display("** rational_arithmetic_unit: FAILED **");
      end
      $finish;
   end

endmodule
